/* rtl/fmr_pkg.sv */
// Shared constants, register codes and cell control type for the find-and-replace unit.
package fmr_pkg;

    localparam int BYTE_W                    = 8;
    localparam int CFG_DATA_W                = 64;
    localparam int CFG_IDX_W                 = 2;
    localparam int LEN_FIELD_W               = 4;
    localparam int DEF_MAX_PATTERN_BYTES     = 8;
    localparam int DEF_MAX_REPLACEMENT_BYTES = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    // Per-cell control: shift pulls the neighbor's byte, sel marks the cell that
    // takes the incoming byte, load commits the candidate byte on accept.
    typedef struct packed {
        logic shift;
        logic sel;
        logic load;
    } cell_ctrl_t;

endpackage

/* rtl/fmr_cell.sv */
// One window cell: holds a byte, shifts from its neighbor, compares against its pattern byte.
module fmr_cell (
    input  logic                           aclk,
    input  fmr_pkg::cell_ctrl_t            ctrl,
    input  logic [fmr_pkg::BYTE_W-1:0]     in_byte,
    input  logic [fmr_pkg::BYTE_W-1:0]     nbr_byte,
    input  logic [fmr_pkg::BYTE_W-1:0]     pat_byte,
    output logic [fmr_pkg::BYTE_W-1:0]     byte_q,
    output logic                           eq
);

    logic [fmr_pkg::BYTE_W-1:0] byte_reg;
    logic [fmr_pkg::BYTE_W-1:0] byte_next;
    logic [fmr_pkg::BYTE_W-1:0] cur_byte;
    logic [fmr_pkg::BYTE_W-1:0] cand_byte;

    always_comb begin
        cur_byte  = ctrl.shift ? nbr_byte : byte_reg;
        cand_byte = ctrl.sel ? in_byte : cur_byte;
        eq        = (cand_byte == pat_byte);
        byte_next = ctrl.load ? cand_byte : cur_byte;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;

endmodule

/* rtl/fmr_cfg.sv */
// Configuration registers with length saturation.
module fmr_cfg #(
    parameter int MAX_PATTERN_BYTES     = fmr_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int MAX_REPLACEMENT_BYTES = fmr_pkg::DEF_MAX_REPLACEMENT_BYTES,
    localparam int CNT_W                = $clog2(MAX_PATTERN_BYTES + 1),
    localparam int RCNT_W               = $clog2(MAX_REPLACEMENT_BYTES + 1)
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        cfg_valid,
    input  logic [fmr_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [fmr_pkg::CFG_DATA_W-1:0]              cfg_data,
    output logic [MAX_PATTERN_BYTES*fmr_pkg::BYTE_W-1:0]     pattern,
    output logic [CNT_W-1:0]                            plen,
    output logic [MAX_REPLACEMENT_BYTES*fmr_pkg::BYTE_W-1:0] repl,
    output logic [RCNT_W-1:0]                           rlen
);

    localparam int PAT_W = MAX_PATTERN_BYTES * fmr_pkg::BYTE_W;
    localparam int REP_W = MAX_REPLACEMENT_BYTES * fmr_pkg::BYTE_W;

    logic [PAT_W-1:0]                     pattern_reg;
    logic [CNT_W-1:0]                     plen_reg;
    logic [REP_W-1:0]                     repl_reg;
    logic [RCNT_W-1:0]                    rlen_reg;
    logic [fmr_pkg::LEN_FIELD_W-1:0]      len_field;
    logic [CNT_W-1:0]                     plen_sat;
    logic [RCNT_W-1:0]                    rlen_sat;

    always_comb begin
        len_field = cfg_data[fmr_pkg::LEN_FIELD_W-1:0];
        if (len_field == '0) begin
            plen_sat = CNT_W'(1);
        end else if (len_field > fmr_pkg::LEN_FIELD_W'(MAX_PATTERN_BYTES)) begin
            plen_sat = CNT_W'(MAX_PATTERN_BYTES);
        end else begin
            plen_sat = CNT_W'(len_field);
        end
        if (len_field > fmr_pkg::LEN_FIELD_W'(MAX_REPLACEMENT_BYTES)) begin
            rlen_sat = RCNT_W'(MAX_REPLACEMENT_BYTES);
        end else begin
            rlen_sat = RCNT_W'(len_field);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            plen_reg    <= CNT_W'(1);
            repl_reg    <= '0;
            rlen_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (fmr_pkg::cfg_reg_t'(cfg_index))
                fmr_pkg::REG_PATTERN_BYTES:      pattern_reg <= cfg_data[PAT_W-1:0];
                fmr_pkg::REG_PATTERN_LENGTH:     plen_reg    <= plen_sat;
                fmr_pkg::REG_REPLACEMENT_BYTES:  repl_reg    <= cfg_data[REP_W-1:0];
                fmr_pkg::REG_REPLACEMENT_LENGTH: rlen_reg    <= rlen_sat;
            endcase
        end
    end

    assign pattern = pattern_reg;
    assign plen    = plen_reg;
    assign repl    = repl_reg;
    assign rlen    = rlen_reg;

endmodule

/* rtl/first_match_replace_unit.sv */
// Top level: streaming find-and-replace of the first pattern occurrence per record.
//
// Bytes enter a chain of window cells, one cell per pattern byte; each cell
// compares its byte with its pattern byte, and a match is tested when the window
// holds exactly the pattern length. The first match of a record is swapped for
// the replacement bytes; all other bytes pass through in order, and the window
// is flushed on the record's final byte. Results leave through a single output
// register at one byte per cycle while m_ready does not hold it off: one item
// per cycle in steady state, and the input holds off while a replacement or
// end-of-record flush drains. Items that cause no result (window filling,
// empty replacement) never hold off the input.
module first_match_replace_unit #(
    parameter int MAX_PATTERN_BYTES     = fmr_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int MAX_REPLACEMENT_BYTES = fmr_pkg::DEF_MAX_REPLACEMENT_BYTES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [fmr_pkg::BYTE_W-1:0]         s_data_byte,
    input  logic                               s_record_end,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fmr_pkg::BYTE_W-1:0]         m_out_byte,
    output logic                               m_out_record_end,
    output logic                               m_run_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fmr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fmr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int P      = MAX_PATTERN_BYTES;
    localparam int R      = MAX_REPLACEMENT_BYTES;
    localparam int BW     = fmr_pkg::BYTE_W;
    localparam int CNT_W  = $clog2(P + 1);
    localparam int RCNT_W = $clog2(R + 1);

    logic [P*BW-1:0]      pattern;
    logic [CNT_W-1:0]     plen;
    logic [R*BW-1:0]      repl;
    logic [RCNT_W-1:0]    rlen;

    fmr_pkg::cell_ctrl_t  cell_ctrl [P];
    logic [BW-1:0]        cell_byte [P];
    logic [P-1:0]         cell_eq;
    logic [P-1:0]         pat_mask;

    // control state
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     pop_reg, pop_next;
    logic [RCNT_W-1:0]    rep_left_reg, rep_left_next;
    logic                 replaced_reg, replaced_next;
    logic                 end_reg, end_next;
    logic                 m_valid_reg, m_valid_next;

    // payload
    logic [R*BW-1:0]      rep_sh_reg, rep_sh_next;
    logic [BW-1:0]        out_byte_reg, out_byte_next;
    logic                 out_end_reg, out_end_next;
    logic                 run_last_reg, run_last_next;

    logic                 pop_run;
    logic                 busy;
    logic                 out_free;
    logic                 emit;
    logic                 is_last;
    logic                 shift;
    logic                 accept;
    logic                 match;
    logic [CNT_W-1:0]     count_eff;
    logic [CNT_W-1:0]     n_items;
    logic [CNT_W-1:0]     k_pop;

    fmr_cfg #(
        .MAX_PATTERN_BYTES     (P),
        .MAX_REPLACEMENT_BYTES (R)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pattern   (pattern),
        .plen      (plen),
        .repl      (repl),
        .rlen      (rlen)
    );

    assign cfg_ready = 1'b1;

    for (genvar i = 0; i < P; i++) begin : g_cell
        logic [BW-1:0] nbr_byte;
        if (i == P - 1) begin : g_tail
            assign nbr_byte = '0;
        end else begin : g_body
            assign nbr_byte = cell_byte[i+1];
        end

        assign cell_ctrl[i].shift = shift;
        assign cell_ctrl[i].sel   = (CNT_W'(i) == count_eff);
        assign cell_ctrl[i].load  = accept;
        assign pat_mask[i]        = (CNT_W'(i) < plen);

        fmr_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl[i]),
            .in_byte  (s_data_byte),
            .nbr_byte (nbr_byte),
            .pat_byte (pattern[i*BW +: BW]),
            .byte_q   (cell_byte[i]),
            .eq       (cell_eq[i])
        );
    end

    always_comb begin
        pop_run   = (pop_reg != '0);
        busy      = pop_run || (rep_left_reg != '0);
        out_free  = !m_valid_reg || m_ready;
        emit      = busy && out_free;
        is_last   = pop_run ? (pop_reg == CNT_W'(1)) : (rep_left_reg == RCNT_W'(1));
        shift     = emit && pop_run;
        // take the next item in the same cycle the final result of a run leaves
        s_ready   = !busy || (out_free && is_last);
        accept    = s_valid && s_ready;
        count_eff = count_reg - CNT_W'(shift);
        n_items   = count_eff + CNT_W'(1);
        match     = !replaced_reg && (n_items == plen) && (&(cell_eq | ~pat_mask));

        if (replaced_reg || s_record_end) begin
            k_pop = n_items;
        end else if (n_items > plen) begin
            // window longer than pattern: drain down to one short of it
            k_pop = n_items - plen + CNT_W'(1);
        end else if (n_items == plen) begin
            k_pop = CNT_W'(1);
        end else begin
            k_pop = '0;
        end
    end

    always_comb begin
        count_next    = count_eff;
        pop_next      = pop_reg - CNT_W'(shift);
        rep_left_next = rep_left_reg - RCNT_W'(emit && !pop_run);
        rep_sh_next   = (emit && !pop_run) ? (rep_sh_reg >> BW) : rep_sh_reg;
        replaced_next = replaced_reg;
        end_next      = end_reg;

        if (accept) begin
            end_next = s_record_end;
            if (match) begin
                count_next    = '0;
                pop_next      = '0;
                rep_left_next = rlen;
                rep_sh_next   = repl;
                replaced_next = !s_record_end;
            end else begin
                count_next    = n_items;
                pop_next      = k_pop;
                rep_left_next = '0;
                replaced_next = replaced_reg && !s_record_end;
            end
        end

        m_valid_next  = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        out_byte_next = out_byte_reg;
        out_end_next  = out_end_reg;
        run_last_next = run_last_reg;
        if (emit) begin
            out_byte_next = pop_run ? cell_byte[0] : rep_sh_reg[BW-1:0];
            run_last_next = is_last;
            out_end_next  = is_last && end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            pop_reg      <= '0;
            rep_left_reg <= '0;
            replaced_reg <= 1'b0;
            end_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            pop_reg      <= pop_next;
            rep_left_reg <= rep_left_next;
            replaced_reg <= replaced_next;
            end_reg      <= end_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rep_sh_reg   <= rep_sh_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
        run_last_reg <= run_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = out_byte_reg;
    assign m_out_record_end = out_end_reg;
    assign m_run_last       = run_last_reg;

endmodule
